### hw/rtl/vld_pkg.sv
package vld_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned ROW_W   = 13;
    localparam int unsigned COL_W   = 12;
    localparam int unsigned WID_W   = 13;
    localparam int unsigned DH_W    = 14;
    localparam int unsigned CFG_W   = 14;

    localparam logic [WID_W-1:0] RESET_SOURCE_WIDTH  = 13'd640;
    localparam logic [WID_W-1:0] RESET_DEST_WIDTH    = 13'd640;
    localparam logic [WID_W-1:0] RESET_SOURCE_HEIGHT = 13'd480;
    localparam logic [DH_W-1:0]  RESET_DEST_HEIGHT   = 14'd960;

    typedef enum logic [1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_DEST_WIDTH    = 2'd1,
        CFG_SOURCE_HEIGHT = 2'd2,
        CFG_DEST_HEIGHT   = 2'd3
    } vld_cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_PAIR   = 2'd2
    } vld_kind_t;

    typedef enum logic {
        PHASE_FIRST  = 1'b0,
        PHASE_SECOND = 1'b1
    } vld_phase_t;

    typedef struct packed {
        logic [PIX_W-1:0] in_pixel;
        logic             frame_start;
    } vld_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [PIX_W-1:0] out_pixel;
        logic             run_last;
    } vld_out_t;

    // geometry derived from the configuration registers
    typedef struct packed {
        logic             active;
        logic [WID_W-1:0] row_len;
        logic [WID_W-1:0] cols_used;
        logic [ROW_W-1:0] rows_used;
    } vld_geom_t;

    // one positioned pixel handed from the counters to the emitter
    typedef struct packed {
        vld_kind_t        kind;
        logic [ROW_W-1:0] row_even;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } vld_item_t;

endpackage

### hw/rtl/vld_cfg_regs.sv
module vld_cfg_regs
    import vld_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH  = 4096,
    parameter int unsigned MAX_SOURCE_ROWS = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  vld_cfg_idx_t       cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output vld_geom_t          geom
);

    localparam logic [31:0] MAX_LW_32 = 32'(MAX_LINE_WIDTH);
    localparam logic [31:0] MAX_SR_32 = 32'(MAX_SOURCE_ROWS);

    logic [WID_W-1:0] src_width_reg;
    logic [WID_W-1:0] dst_width_reg;
    logic [WID_W-1:0] src_height_reg;
    logic [DH_W-1:0]  dst_height_reg;

    logic [WID_W-1:0] row_len;
    logic [WID_W-1:0] sh_cap;
    logic [ROW_W-1:0] dh_half;
    logic [ROW_W-1:0] rows_a;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RESET_SOURCE_WIDTH;
            dst_width_reg  <= RESET_DEST_WIDTH;
            src_height_reg <= RESET_SOURCE_HEIGHT;
            dst_height_reg <= RESET_DEST_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  src_width_reg  <= cfg_data[WID_W-1:0];
                CFG_DEST_WIDTH:    dst_width_reg  <= cfg_data[WID_W-1:0];
                CFG_SOURCE_HEIGHT: src_height_reg <= cfg_data[WID_W-1:0];
                CFG_DEST_HEIGHT:   dst_height_reg <= cfg_data[DH_W-1:0];
                default:           src_width_reg  <= src_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (src_width_reg == '0)
            row_len = WID_W'(1);
        else if (32'(src_width_reg) > MAX_LW_32)
            row_len = WID_W'(MAX_LINE_WIDTH);
        else
            row_len = src_width_reg;

        if (32'(src_height_reg) > MAX_SR_32)
            sh_cap = WID_W'(MAX_SOURCE_ROWS);
        else
            sh_cap = src_height_reg;

        dh_half = dst_height_reg[DH_W-1:1];
        rows_a  = dst_height_reg[0] ? dh_half : dh_half - ROW_W'(1);

        geom.active    = (sh_cap != '0) && (dst_height_reg != '0);
        geom.row_len   = row_len;
        geom.cols_used = (row_len < dst_width_reg) ? row_len : dst_width_reg;
        geom.rows_used = (32'(rows_a) >= 32'(sh_cap)) ? ROW_W'(sh_cap - WID_W'(1)) : rows_a;
    end

endmodule

### hw/rtl/vld_position.sv
module vld_position
    import vld_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH  = 4096,
    parameter int unsigned MAX_SOURCE_ROWS = 4096,
    localparam int unsigned CW = $clog2(MAX_LINE_WIDTH),
    localparam int unsigned RW = $clog2(MAX_SOURCE_ROWS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  vld_in_t       in_data,
    input  vld_geom_t     geom,
    output vld_item_t     item,
    output logic [CW-1:0] mem_addr
);

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [CW-1:0] col_cur;
    logic [CW-1:0] col_c;
    logic [RW-1:0] row_cur;
    logic          in_use;
    logic          wrap;

    always_comb
    begin
        col_cur = in_data.frame_start ? '0 : col_reg;
        row_cur = in_data.frame_start ? '0 : row_reg;

        // column left beyond the row end by a width change is pinned to the last column
        if (32'(col_cur) >= 32'(geom.row_len))
            col_c = CW'(geom.row_len - WID_W'(1));
        else
            col_c = col_cur;

        in_use = geom.active
                 && (32'(col_c) < 32'(geom.cols_used))
                 && (32'(row_cur) <= 32'(geom.rows_used));

        item.col      = COL_W'(col_c);
        item.row_even = ROW_W'({row_cur, 1'b0});
        item.pix      = in_data.in_pixel;
        if (!in_use)
            item.kind = KIND_NONE;
        else if (row_cur == '0)
            item.kind = KIND_SINGLE;
        else
            item.kind = KIND_PAIR;

        wrap = (32'(col_c) + 32'd1) >= 32'(geom.row_len);
        col_next = wrap ? '0 : col_c + CW'(1);
        if (wrap && (32'(row_cur) < 32'(MAX_SOURCE_ROWS)))
            row_next = row_cur + RW'(1);
        else
            row_next = row_cur;
    end

    assign mem_addr = col_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### hw/rtl/vld_line_buffer.sv
module vld_line_buffer
    import vld_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH = 4096,
    localparam int unsigned CW = $clog2(MAX_LINE_WIDTH)
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [CW-1:0]    addr,
    input  logic [PIX_W-1:0] wdata,
    output logic [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] rdata_reg;

    // read-first: the pixel above comes out while this pixel replaces it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/vld_emitter.sv
module vld_emitter
    import vld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  vld_item_t        item,
    input  logic [PIX_W-1:0] above,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_stall,
    output vld_out_t         out_data
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    vld_item_t  s1_item_reg;
    vld_phase_t phase_reg;
    vld_phase_t phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    vld_out_t   out_reg;
    vld_out_t   beat;

    logic       out_free;
    logic       beat_go;
    logic       retire;
    logic [PIX_W:0] pix_sum;

    assign out_free = !out_valid_reg || !out_stall;
    assign beat_go  = s1_valid_reg && (s1_item_reg.kind != KIND_NONE) && out_free;

    always_comb
    begin
        retire = 1'b0;
        if (s1_valid_reg)
        begin
            unique case (s1_item_reg.kind)
                KIND_NONE:   retire = 1'b1;
                KIND_SINGLE: retire = out_free;
                KIND_PAIR:   retire = out_free && (phase_reg == PHASE_SECOND);
                default:     retire = 1'b1;
            endcase
        end
    end

    assign busy = s1_valid_reg && !retire;

    always_comb
    begin
        pix_sum = {1'b0, above} + {1'b0, s1_item_reg.pix};
        beat.out_col = s1_item_reg.col;
        if ((s1_item_reg.kind == KIND_PAIR) && (phase_reg == PHASE_FIRST))
        begin
            beat.out_row   = s1_item_reg.row_even - ROW_W'(1);
            beat.out_pixel = pix_sum[PIX_W:1];
            beat.run_last  = 1'b0;
        end
        else
        begin
            beat.out_row   = s1_item_reg.row_even;
            beat.out_pixel = s1_item_reg.pix;
            beat.run_last  = 1'b1;
        end
    end

    // phase sequencing
    always_comb
    begin
        priority if (take)
            phase_next = PHASE_FIRST;
        else if (beat_go && (phase_reg == PHASE_FIRST))
            phase_next = PHASE_SECOND;
        else
            phase_next = phase_reg;
    end

    always_comb
    begin
        priority if (take)
            s1_valid_next = 1'b1;
        else if (retire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        priority if (beat_go)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PHASE_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_item_reg <= item;
        if (beat_go)
            out_reg <= beat;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_second_is_pair: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (phase_reg == PHASE_SECOND) |-> s1_item_reg.kind == KIND_PAIR)
        else $error("second phase on an item that is not a pair");

    a_second_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (phase_reg == PHASE_SECOND) |-> out_valid_reg)
        else $error("second phase without the first beat in the output register");

    a_first_beat_has_partner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.run_last |-> s1_valid_reg && (phase_reg == PHASE_SECOND))
        else $error("interpolated beat shown with no pending second beat");

    a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !s1_valid_reg || retire)
        else $error("new pixel taken over an unfinished one");

endmodule

### hw/rtl/vertical_line_doubler.sv
// Path: a taken pixel is registered with the pixel above from the line buffer, then its first
// result beat is registered in the output register, which out_stall can hold.
// Throughput: one pixel per cycle with no result, or with one result (source row 0) while the output
// is free; a pixel with two results stalls the input until its second beat goes out. The single output
// register moves one beat per cycle unless stalled; the line buffer is read and written once per pixel.
// Reset: counters clear, registers load 640/640/480/960; the line buffer is not cleared.
module vertical_line_doubler
    import vld_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH  = 4096,
    parameter int unsigned MAX_SOURCE_ROWS = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  vld_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output vld_out_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  vld_cfg_idx_t     cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);

    vld_geom_t        geom;
    vld_item_t        item;
    logic [CW-1:0]    mem_addr;
    logic [PIX_W-1:0] above;
    logic             take;
    logic             busy;

    assign in_stall = busy;
    assign take     = in_valid && !busy;

    vld_cfg_regs #(
        .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
        .MAX_SOURCE_ROWS (MAX_SOURCE_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    vld_position #(
        .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
        .MAX_SOURCE_ROWS (MAX_SOURCE_ROWS)
    ) u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_data  (in_data),
        .geom     (geom),
        .item     (item),
        .mem_addr (mem_addr)
    );

    vld_line_buffer #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_buf (
        .clk   (clk),
        .en    (take),
        .addr  (mem_addr),
        .wdata (in_data.in_pixel),
        .rdata (above)
    );

    vld_emitter u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .above     (above),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### bench/vld_checker.sv
`timescale 1ns / 100ps

module vld_checker
    import vld_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH  = 4096,
    parameter int unsigned MAX_SOURCE_ROWS = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  vld_in_t          in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  vld_out_t         out_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  vld_cfg_idx_t     cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               mismatch_count,
    output int               outstanding
);

    logic [WID_W-1:0] src_width;
    logic [WID_W-1:0] dst_width;
    logic [WID_W-1:0] src_height;
    logic [DH_W-1:0]  dst_height;

    int unsigned      src_col;
    int unsigned      src_row;
    logic [PIX_W-1:0] line_above [MAX_LINE_WIDTH];

    vld_out_t         expected_writes [$];

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    function automatic vld_out_t make_write(input int unsigned row, input int unsigned col,
                                            input int unsigned pix, input bit last);
        vld_out_t w;
        w.out_row   = ROW_W'(row);
        w.out_col   = COL_W'(col);
        w.out_pixel = PIX_W'(pix);
        w.run_last  = last;
        return w;
    endfunction

    task automatic queue_write(input vld_out_t w);
        expected_writes = {expected_writes, w};
    endtask

    task automatic predict_pixel(input vld_in_t beat);
        int unsigned row_len;
        int unsigned cols_used;
        int unsigned rows_avail;
        int unsigned rows_used;
        int unsigned col;
        int unsigned row;
        int unsigned above;
        bit          emit_ok;
        if (beat.frame_start)
        begin
            src_col = 0;
            src_row = 0;
        end
        row_len = src_width;
        if (row_len < 1)
            row_len = 1;
        if (row_len > MAX_LINE_WIDTH)
            row_len = MAX_LINE_WIDTH;
        cols_used  = (row_len < dst_width) ? row_len : dst_width;
        rows_avail = (src_height > MAX_SOURCE_ROWS) ? MAX_SOURCE_ROWS : src_height;
        col = (src_col >= row_len) ? row_len - 1 : src_col;
        row = src_row;

        if (rows_avail != 0 && dst_height != 0 && col < cols_used)
        begin
            rows_used = dst_height / 2;
            if (!dst_height[0])
                rows_used = rows_used - 1;
            if (rows_used >= rows_avail)
                rows_used = rows_avail - 1;
            // a two-row destination only takes the first source row
            emit_ok = (dst_height == 2) ? (row == 0) : (row <= rows_used);
            if (emit_ok)
            begin
                if (row == 0)
                    queue_write(make_write(0, col, beat.in_pixel, 1'b1));
                else
                begin
                    above = line_above[col];
                    queue_write(make_write(2 * row - 1, col,
                                           (above + beat.in_pixel) >> 1, 1'b0));
                    queue_write(make_write(2 * row, col, beat.in_pixel, 1'b1));
                end
            end
        end

        line_above[col] = beat.in_pixel;
        col = col + 1;
        if (col >= row_len)
        begin
            col = 0;
            if (row < MAX_SOURCE_ROWS)
                row = row + 1;
        end
        src_col = col;
        src_row = row;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // handshakes are stable mid-cycle; each beat completes at the following rising edge
    always @(negedge clk)
    begin
        vld_out_t want;
        if (!rst_n)
        begin
            src_width  = RESET_SOURCE_WIDTH;
            dst_width  = RESET_DEST_WIDTH;
            src_height = RESET_SOURCE_HEIGHT;
            dst_height = RESET_DEST_HEIGHT;
            src_col    = 0;
            src_row    = 0;
            expected_writes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  src_width  = cfg_data[WID_W-1:0];
                    CFG_DEST_WIDTH:    dst_width  = cfg_data[WID_W-1:0];
                    CFG_SOURCE_HEIGHT: src_height = cfg_data[WID_W-1:0];
                    CFG_DEST_HEIGHT:   dst_height = cfg_data[DH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_pixel(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write: row %0d col %0d pixel %0d last %0d",
                           out_data.out_row, out_data.out_col, out_data.out_pixel,
                           out_data.run_last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("out_row", 16'(want.out_row), 16'(out_data.out_row));
                    check_field("out_col", 16'(want.out_col), 16'(out_data.out_col));
                    check_field("out_pixel", 16'(want.out_pixel), 16'(out_data.out_pixel));
                    check_field("run_last", 16'(want.run_last), 16'(out_data.run_last));
                end
            end
        end
        outstanding = expected_writes.size();
    end

endmodule

### bench/vertical_line_doubler_tb.sv
`timescale 1ns / 100ps

module vertical_line_doubler_tb;
    import vld_pkg::*;

    localparam int unsigned LINE_MAX      = 4096;
    localparam int unsigned ROWS_MAX      = 4096;
    localparam int unsigned RANDOM_PIXELS = 1100;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 2000000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    vld_in_t          in_data;
    logic             out_valid;
    logic             out_stall = 1'b0;
    vld_out_t         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    vld_cfg_idx_t     cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               mismatch_count;
    int               outstanding;
    int unsigned      gap_pct;
    int unsigned      stall_pct;
    int unsigned      pixels_sent;
    int unsigned      cycle_count = 0;

    vertical_line_doubler #(
        .MAX_LINE_WIDTH  (LINE_MAX),
        .MAX_SOURCE_ROWS (ROWS_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vld_checker #(
        .MAX_LINE_WIDTH  (LINE_MAX),
        .MAX_SOURCE_ROWS (ROWS_MAX)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 62; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 62; end
            default: begin gap_pct = 21; stall_pct = 21; end
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_pixel: pix, frame_start: fs};
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        pixels_sent++;
    endtask

    // wait for every expected write, then let pixels that give none drain
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input vld_cfg_idx_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic program_geometry(input int unsigned sw, input int unsigned dw,
                                    input int unsigned sh, input int unsigned dh);
        settle();
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_DEST_WIDTH, dw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_DEST_HEIGHT, dh);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frames(input int unsigned row_len, input int unsigned n_rows,
                               input int unsigned n_frames, input bit noisy);
        int unsigned total;
        bit          fs;
        total = row_len * n_rows;
        for (int unsigned f = 0; f < n_frames; f++)
        begin
            for (int unsigned i = 0; i < total; i++)
            begin
                fs = (i == 0) || (noisy && $urandom_range(99) < 3);
                send_pixel(PIX_W'($urandom_range(255)), fs);
                // cut the frame short now and then
                if (noisy && $urandom_range(99) == 0)
                    break;
            end
        end
    endtask

    initial
    begin
        int unsigned sw;
        int unsigned dw;
        int unsigned sh;
        int unsigned dh;
        int unsigned rows;
        int unsigned first_random;
        int unsigned phase;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_SOURCE_WIDTH;
        cfg_data    <= '0;
        gap_pct     = 0;
        stall_pct   = 0;
        pixels_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry, counters start at row 0 without a frame start
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h5A, 1'b0);

        // two interpolated rows, then a row past the source
        program_geometry(2, 2, 3, 5);
        set_idling(1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h33, 1'b0);
        send_pixel(8'hCC, 1'b0);

        // zero source width, tall source, two-row destination
        program_geometry(0, 8191, 8191, 2);
        set_idling(2);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'hFF, 1'b0);

        // over-wide source, zero dest width, zero source height
        program_geometry(8191, 0, 0, 16383);
        set_idling(3);
        send_pixel(8'h11, 1'b1);
        send_pixel(8'hEE, 1'b0);

        // zero dest height
        program_geometry(3, 3, 4, 0);
        send_pixel(8'h22, 1'b1);
        send_pixel(8'hDD, 1'b0);

        // single dest row: nothing past source row 0
        program_geometry(1, 1, 4096, 1);
        set_idling(0);
        send_pixel(8'h44, 1'b1);
        send_pixel(8'hBB, 1'b0);

        // narrow dest, frame restart in the middle of a row
        program_geometry(2, 1, 2, 16383);
        set_idling(1);
        send_pixel(8'hF0, 1'b1);
        send_pixel(8'h0F, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFE, 1'b1);
        send_pixel(8'h10, 1'b0);

        // long line, two rows
        program_geometry(64, 64, 2, 3);
        set_idling(0);
        send_frames(64, 2, 1, 1'b0);

        first_random = pixels_sent;
        phase = 0;
        while (pixels_sent - first_random < RANDOM_PIXELS)
        begin
            case ($urandom_range(9))
                0:       sw = 0;
                1:       sw = $urandom_range(11, 24);
                default: sw = $urandom_range(1, 10);
            endcase
            case ($urandom_range(19))
                0, 1:    dw = 0;
                2, 3, 4: dw = $urandom_range(13, 8191);
                default: dw = $urandom_range(1, 12);
            endcase
            case ($urandom_range(9))
                0:       sh = 0;
                1:       sh = $urandom_range(4097, 8191);
                default: sh = $urandom_range(1, 8);
            endcase
            case ($urandom_range(9))
                0:       dh = 0;
                1:       dh = 2;
                2:       dh = $urandom_range(21, 16383);
                default: dh = $urandom_range(1, 20);
            endcase
            program_geometry(sw, dw, sh, dh);
            set_idling(phase);
            rows = (sh == 0) ? 2 : ((sh > 8) ? 8 : sh) + $urandom_range(0, 2);
            send_frames((sw == 0) ? 1 : sw, rows, $urandom_range(1, 3),
                        $urandom_range(99) < 30);
            phase++;
        end

        settle();
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
